FILE: rtl/core/sld_pkg.sv
// Shared types, constants and status codes for the second-latest valid date block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
   localparam int TDATA_W = ((KEY_W + 7) / 8) * 8;
   localparam int COUNT_W = 2;

   localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
   localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);

   localparam logic [DAY_W-1:0] DAY_MIN   = DAY_W'(1);
   localparam logic [DAY_W-1:0] DAY_FEB   = DAY_W'(29);
   localparam logic [DAY_W-1:0] DAY_SHORT = DAY_W'(30);
   localparam logic [DAY_W-1:0] DAY_LONG  = DAY_W'(31);

   localparam logic [COUNT_W-1:0] COUNT_NONE = COUNT_W'(0);
   localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_TWO  = COUNT_W'(2);

   typedef enum logic [1:0] {
      STATUS_ACCEPT  = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_RESULT  = 2'd2,
      STATUS_TOO_FEW = 2'd3
   } status_type;

   // key order: year high, day low, so a plain compare ranks dates
   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   typedef struct packed {
      logic     ok;
      logic     last;
      date_type date;
   } check_type;

   typedef struct packed {
      status_type status;
      date_type   date;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/core/sld_check.sv
// Calendar check of one date: month range and day range per month.
// Depends on sld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sld_check (
   input  sld_pkg::date_type  date,
   input  wire logic          last,
   output sld_pkg::check_type chk
);
   import sld_pkg::*;

   logic [DAY_W-1:0] day_top;
   logic             month_ok;

   always_comb begin
      month_ok = (date.month >= MONTH_MIN) && (date.month <= MONTH_MAX);
      unique case (date.month)
         MONTH_FEB: begin
            day_top = DAY_FEB;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            day_top = DAY_SHORT;
         end
         default: begin
            day_top = DAY_LONG;
         end
      endcase
      chk.ok   = month_ok && (date.day >= DAY_MIN) && (date.day <= day_top);
      chk.last = last;
      chk.date = date;
   end

endmodule

`default_nettype wire

FILE: rtl/core/sld_track.sv
// Top-two tracker: holds the latest and runner-up dates of the open batch
// and forms the result of each request. Depends on sld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sld_track (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  sld_pkg::check_type  chk,
   output sld_pkg::result_type res
);
   import sld_pkg::*;

   date_type            latest_ff, latest_in;
   date_type            runner_ff, runner_in;
   logic [COUNT_W-1:0]  count_ff,  count_in;
   date_type            runner_new;
   logic [COUNT_W-1:0]  count_new;

   always_comb begin
      latest_in  = latest_ff;
      runner_new = runner_ff;
      count_new  = count_ff;
      res.status = STATUS_INVALID;
      res.date   = '0;
      if (chk.ok) begin
         priority if (count_ff == COUNT_NONE) begin
            latest_in = chk.date;
            count_new = COUNT_ONE;
         end else if (chk.date > latest_ff) begin
            runner_new = latest_ff;
            latest_in  = chk.date;
            count_new  = COUNT_TWO;
         end else if (count_ff == COUNT_ONE || chk.date > runner_ff) begin
            runner_new = chk.date;
            count_new  = COUNT_TWO;
         end else begin
            count_new  = count_ff;
         end
         res.status = STATUS_ACCEPT;
      end
      runner_in = runner_new;
      count_in  = count_new;
      if (chk.ok && chk.last) begin
         if (count_new == COUNT_TWO) begin
            res.status = STATUS_RESULT;
            res.date   = runner_new;
         end else begin
            res.status = STATUS_TOO_FEW;
         end
         latest_in = '0;
         runner_in = '0;
         count_in  = COUNT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff <= '0;
         runner_ff <= '0;
         count_ff  <= COUNT_NONE;
      end else if (step) begin
         latest_ff <= latest_in;
         runner_ff <= runner_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/second_latest_valid_date.sv
// Second-latest valid date over a batch: top level with request and response registers.
// Depends on sld_pkg, sld_check and sld_track.
//
// Usage:
//   Requests enter on req_* (one date per request, req_tlast marks the batch end).
//   Every request gives exactly one response on rsp_*; rsp_tuser carries the status:
//   accepted, rejected invalid, batch result (second-latest date in rsp_tdata) or
//   too few dates. An invalid date with req_tlast set does not close the batch.
//   The request register loads at acceptance and the response register when the
//   request moves on out of it, with the check and top-two update between them.
//   Throughput: one request per cycle while rsp_tready stays high; the tracker
//   state updates once per request as it moves from the request register into
//   the response register.
//   Stall: when rsp_tready is low the response is held; one more request may wait
//   in the request register, after which req_tready drops.
//   Reset: synchronous; clears both valid flags and the batch state (empty batch).
`timescale 1ns / 1ps
`default_nettype none

module second_latest_valid_date (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sld_pkg::TDATA_W-1:0] req_tdata,  // year, month, day, zero pad
   input  wire logic                        req_tlast,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [sld_pkg::TDATA_W-1:0]      rsp_tdata,  // year, month, day, zero pad
   output logic [1:0]                       rsp_tuser   // status
);
   import sld_pkg::*;

   logic       req_valid_ff;
   date_type   req_date_ff;
   logic       req_last_ff;
   logic       rsp_valid_ff;
   result_type rsp_res_ff;
   logic       step;
   check_type  chk;
   result_type res;
   date_type   req_date;

   assign req_date   = {req_tdata[YEAR_W-1:0], req_tdata[YEAR_W +: MONTH_W],
                        req_tdata[YEAR_W + MONTH_W +: DAY_W]};
   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_date_ff <= req_date;
         req_last_ff <= req_tlast;
      end
   end

   sld_check u_check (
      .date (req_date_ff),
      .last (req_last_ff),
      .chk  (chk)
   );

   sld_track u_track (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .chk   (chk),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = TDATA_W'({rsp_res_ff.date.day, rsp_res_ff.date.month,
                                 rsp_res_ff.date.year});

endmodule

`default_nettype wire

FILE: rtl/core/sld_checker.sv
// Port-level checks for the second-latest valid date block, bound to the top level.
// Depends on sld_pkg and second_latest_valid_date.
`timescale 1ns / 1ps
`default_nettype none

module sld_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [sld_pkg::TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]                  rsp_tuser
);
   import sld_pkg::*;

   logic [MONTH_W-1:0] rsp_month;
   logic [DAY_W-1:0]   rsp_day;

   assign rsp_month = rsp_tdata[YEAR_W +: MONTH_W];
   assign rsp_day   = rsp_tdata[YEAR_W + MONTH_W +: DAY_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_RESULT |-> rsp_tdata == '0)
      else $error("date fields not zero outside a batch result");

   a_result_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_RESULT |->
         rsp_month >= MONTH_MIN && rsp_month <= MONTH_MAX && rsp_day != '0)
      else $error("batch result holds an invalid date");

endmodule

bind second_latest_valid_date sld_checker u_sld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: tb/sv/sld_date_checker.sv
// Checker for the second-latest valid date block: watches both stream channels,
// predicts each response from the accepted requests and compares field by field.
// Depends on sld_pkg; instantiated beside the block by tb_second_latest_valid_date.
`timescale 1ns / 1ps
`default_nettype none

module sld_date_checker
   import sld_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tready,
   input  wire logic [TDATA_W-1:0] req_tdata,   // year, month, day, zero pad
   input  wire logic               req_tlast,
   input  wire logic               rsp_tvalid,
   input  wire logic               rsp_tready,
   input  wire logic [TDATA_W-1:0] rsp_tdata,   // year, month, day, zero pad
   input  wire logic [1:0]         rsp_tuser,   // status
   output int                      mismatch_count,
   output int                      outstanding
);

   localparam int MONTH_LO = YEAR_W;
   localparam int DAY_LO   = YEAR_W + MONTH_W;

   date_type         top_date;
   date_type         second_date;
   logic [COUNT_W-1:0] dates_held;
   result_type       pending_results[$];

   function automatic date_type unpack_date(input logic [TDATA_W-1:0] bus);
      date_type d;
      d.year  = bus[YEAR_W-1:0];
      d.month = bus[MONTH_LO +: MONTH_W];
      d.day   = bus[DAY_LO +: DAY_W];
      return d;
   endfunction

   function automatic logic calendar_ok(input date_type d);
      logic [DAY_W-1:0] month_end;
      if (d.month < MONTH_MIN || d.month > MONTH_MAX)
         return 1'b0;
      case (d.month)
         MONTH_FEB: month_end = DAY_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_end = DAY_SHORT;
         default: month_end = DAY_LONG;
      endcase
      return d.day >= DAY_MIN && d.day <= month_end;
   endfunction

   // updates the top-two tracking and returns the response this request should give
   function automatic result_type rank_date(input date_type d, input logic last);
      result_type r;
      r.status = STATUS_ACCEPT;
      r.date   = '0;
      if (!calendar_ok(d)) begin
         r.status = STATUS_INVALID;
         return r;
      end
      if (dates_held == COUNT_NONE) begin
         top_date   = d;
         dates_held = COUNT_ONE;
      end else if (d > top_date) begin
         second_date = top_date;
         top_date    = d;
         dates_held  = COUNT_TWO;
      end else if (dates_held == COUNT_ONE || d > second_date) begin
         second_date = d;
         dates_held  = COUNT_TWO;
      end
      if (!last)
         return r;
      if (dates_held == COUNT_TWO) begin
         r.status = STATUS_RESULT;
         r.date   = second_date;
      end else begin
         r.status = STATUS_TOO_FEW;
      end
      top_date    = '0;
      second_date = '0;
      dates_held  = COUNT_NONE;
      return r;
   endfunction

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      date_type   got;
      if (reset) begin
         top_date    = '0;
         second_date = '0;
         dates_held  = COUNT_NONE;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_date(rsp_tdata);
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d date %0d-%0d-%0d",
                        $time, rsp_tuser, got.year, got.month, got.day);
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_tuser));
               check_field("year", 16'(want.date.year), 16'(got.year));
               check_field("month", 16'(want.date.month), 16'(got.month));
               check_field("day", 16'(want.date.day), 16'(got.day));
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(rank_date(unpack_date(req_tdata), req_tlast));
      end
      outstanding = pending_results.size();
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb_second_latest_valid_date.sv
// Testbench top for second_latest_valid_date: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on sld_pkg and sld_date_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_second_latest_valid_date;
   import sld_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 450;
   localparam int PRESSURE_ITEMS = 60;
   localparam int DRAIN_CYCLES = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;   // year, month, day, zero pad
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;        // year, month, day, zero pad
   logic [1:0]         rsp_tuser;        // status

   int       mismatch_count;
   int       outstanding;
   int       send_idle_pct = 0;
   int       stall_pct = 0;
   logic     hold_trigger = 1'b0;
   logic     hold_used = 1'b0;
   int       hold_left = 0;
   date_type recent_date = '0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   second_latest_valid_date u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sld_date_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // response side: random stalls, plus one long hold-off to fill the block
   always @(negedge clock) begin
      if (hold_trigger && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_date(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month,
                            input logic [DAY_W-1:0] day, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'({day, month, year});
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_noise();
      send_date(YEAR_W'($urandom_range(16383)), MONTH_W'($urandom_range(15)),
                DAY_W'($urandom_range(31)), 1'($urandom_range(1)));
   endtask

   // calendar-valid date; narrow year window and repeats give ties and near-ties
   task automatic send_valid(input logic last);
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [DAY_W-1:0]   month_end;
      int                 pick;
      pick  = $urandom_range(99);
      month = MONTH_W'($urandom_range(1, 12));
      case (month)
         MONTH_FEB: month_end = DAY_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_end = DAY_SHORT;
         default: month_end = DAY_LONG;
      endcase
      day  = ($urandom_range(3) == 0) ? month_end : DAY_W'($urandom_range(1, month_end));
      year = (pick < 60) ? YEAR_W'($urandom_range(1995, 2005)) : YEAR_W'($urandom_range(16383));
      if (pick >= 85 && recent_date != '0)
         {year, month, day} = recent_date;
      recent_date = {year, month, day};
      send_date(year, month, day, last);
   endtask

   task automatic run_batches(input int item_total);
      int sent;
      int batch_len;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(99) < 12) begin
            send_noise();
            sent++;
         end else begin
            batch_len = $urandom_range(1, 5);
            for (int i = 0; i < batch_len; i++) begin
               if ($urandom_range(99) < 8) begin
                  send_noise();
                  sent++;
               end
               send_valid(i == batch_len - 1);
               sent++;
            end
         end
      end
   endtask

   // sender goes quiet so the last request is not offered again
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone date closing a batch: too few
      send_date(14'd2000, 4'd1, 5'd1, 1'b1);
      // field extremes, year beyond 9999 included
      send_date(14'd0, 4'd1, 5'd1, 1'b0);
      send_date(14'd16383, 4'd12, 5'd31, 1'b0);
      send_date(14'd9999, 4'd2, 5'd29, 1'b1);
      // invalid dates, some marked last, none may close the batch; then a valid 30 November closes it with too few
      send_date(14'd100, 4'd0, 5'd5, 1'b1);
      send_date(14'd100, 4'd13, 5'd1, 1'b0);
      send_date(14'd100, 4'd15, 5'd31, 1'b1);
      send_date(14'd100, 4'd1, 5'd0, 1'b1);
      send_date(14'd100, 4'd2, 5'd30, 1'b0);
      send_date(14'd100, 4'd4, 5'd31, 1'b0);
      send_date(14'd100, 4'd6, 5'd31, 1'b0);
      send_date(14'd100, 4'd9, 5'd31, 1'b0);
      send_date(14'd100, 4'd11, 5'd31, 1'b1);
      send_date(14'd100, 4'd11, 5'd30, 1'b1);
      // equal dates count twice
      send_date(14'd5, 4'd5, 5'd5, 1'b0);
      send_date(14'd5, 4'd5, 5'd5, 1'b1);
      // ordering by day, then a newer year
      send_date(14'd300, 4'd3, 5'd31, 1'b0);
      send_date(14'd300, 4'd3, 5'd30, 1'b0);
      send_date(14'd300, 4'd3, 5'd29, 1'b0);
      send_date(14'd301, 4'd1, 5'd1, 1'b1);
      send_date(14'd8191, 4'd7, 5'd16, 1'b0);
      send_date(14'd8192, 4'd8, 5'd15, 1'b0);
      send_date(14'd8192, 4'd10, 5'd31, 1'b1);
      wait_for_drain();

      run_batches(PHASE_ITEMS);
      wait_for_drain();

      send_idle_pct = 59;
      run_batches(PHASE_ITEMS);
      wait_for_drain();

      send_idle_pct = 0;
      hold_trigger  = 1'b1;
      run_batches(PRESSURE_ITEMS);
      wait_for_drain();

      stall_pct = 59;
      run_batches(PHASE_ITEMS);
      wait_for_drain();

      send_idle_pct = 38;
      stall_pct     = 38;
      run_batches(PHASE_ITEMS);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
